@@ hdl/mfmcb_pkg.sv @@
// Package for the MFM cell builder: field widths, operation, element and status codes,
// and the byte-to-MFM encoding function. No dependencies.
package mfmcb_pkg;

   // Width of the cell position and length counters.
   localparam int CellCountBits = 20;
   localparam int OpBits        = 3;
   localparam int KindBits      = 3;
   localparam int StatusBits    = 3;
   localparam int CountBits     = 5;

   // Operation codes carried by a request transaction.
   localparam logic [OpBits-1:0] OP_TRACK_START = 3'd0;
   localparam logic [OpBits-1:0] OP_BLOCK_START = 3'd1;
   localparam logic [OpBits-1:0] OP_ELEMENT     = 3'd2;
   localparam logic [OpBits-1:0] OP_FUZZY       = 3'd3;
   localparam logic [OpBits-1:0] OP_BLOCK_END   = 3'd4;
   localparam logic [OpBits-1:0] OP_TRACK_END   = 3'd5;

   // Element kinds.
   localparam logic [KindBits-1:0] KIND_SYNC = 3'd1;
   localparam logic [KindBits-1:0] KIND_DATA = 3'd2;
   localparam logic [KindBits-1:0] KIND_GAP  = 3'd3;
   localparam logic [KindBits-1:0] KIND_RAW  = 3'd4;

   // Status codes; anything but ST_OK is sticky until the next track start.
   localparam logic [StatusBits-1:0] ST_OK       = 3'd0;
   localparam logic [StatusBits-1:0] ST_OVERFLOW = 3'd1;
   localparam logic [StatusBits-1:0] ST_BLOCK    = 3'd2;
   localparam logic [StatusBits-1:0] ST_ODD_GAP  = 3'd3;
   localparam logic [StatusBits-1:0] ST_BAD_TYPE = 3'd4;
   localparam logic [StatusBits-1:0] ST_TRACK    = 3'd5;

   localparam logic [CountBits-1:0] COUNT_NONE = 5'd0;
   localparam logic [CountBits-1:0] COUNT_RAW  = 5'd8;
   localparam logic [CountBits-1:0] COUNT_MFM  = 5'd16;

   typedef logic [CellCountBits-1:0] cell_cnt_type;

   // Encodes one byte, MSB first, into 16 MFM cells (clock, data pairs). The clock
   // cell is set when the previous and the current data bit are both zero.
   function automatic logic [15:0] mfm_encode(input logic [7:0] value, input logic prev_bit);
      logic [15:0] acc;
      logic        prev;
      acc  = '0;
      prev = prev_bit;
      for (int i = 7; i >= 0; i--) begin
         acc[2*i+1] = ~prev & ~value[i];
         acc[2*i]   = value[i];
         prev       = value[i];
      end
      return acc;
   endfunction

endpackage

@@ hdl/mfmcb_if.sv @@
// Request and response channel interfaces of the MFM cell builder.
// Depends on mfmcb_pkg for field widths.
interface mfmcb_req_if import mfmcb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OpBits-1:0]     op;
   logic [19:0]           track_cells;
   logic [19:0]           block_cells;
   logic [19:0]           gap_cells;
   logic [KindBits-1:0]   elem_kind;
   logic [7:0]            value_byte;
   logic [19:0]           fuzzy_cells;

   modport source (output valid, op, track_cells, block_cells, gap_cells, elem_kind,
                   value_byte, fuzzy_cells, input ready);
   modport sink   (input valid, op, track_cells, block_cells, gap_cells, elem_kind,
                   value_byte, fuzzy_cells, output ready);
endinterface

interface mfmcb_rsp_if import mfmcb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [15:0]           cells;
   logic [CountBits-1:0]  cell_count;
   logic [19:0]           run_cells;
   logic                  run_is_gap;
   logic                  gap_first_cell;
   logic [StatusBits-1:0] status;
   logic                  track_done;

   modport source (output valid, cells, cell_count, run_cells, run_is_gap, gap_first_cell,
                   status, track_done, input ready);
   modport sink   (input valid, cells, cell_count, run_cells, run_is_gap, gap_first_cell,
                   status, track_done, output ready);
endinterface

@@ hdl/track_element_mfm_cell_builder.sv @@
// Each response is registered: it appears in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; the response register is refilled in the same
// cycle it is drained, so the request side only stalls while a response waits unread.
// Reset (synchronous, active high) clears all track state, the sticky error and the
// response valid flag.
module track_element_mfm_cell_builder
   import mfmcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mfmcb_req_if.sink    req_chan,
   mfmcb_rsp_if.source  rsp_chan
);

   // Track state. All of it updates at the edge that accepts a request, so the next
   // request sees it immediately.
   cell_cnt_type           cell_pos_ff,    cell_pos_in;
   cell_cnt_type           block_start_ff, block_start_in;
   cell_cnt_type           exp_track_ff,   exp_track_in;
   cell_cnt_type           exp_block_ff,   exp_block_in;
   logic                   last_bit_ff,    last_bit_in;
   logic [StatusBits-1:0]  err_ff,         err_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic [15:0]            cells_ff,       cells_in;
   logic [CountBits-1:0]   count_ff,       count_in;
   logic [19:0]            run_ff,         run_in;
   logic                   is_gap_ff,      is_gap_in;
   logic                   first_ff,       first_in;
   logic                   done_ff,        done_in;

   logic                   accept;
   cell_cnt_type           need;
   logic [CellCountBits:0] need_sum;
   logic                   overflow;
   cell_cnt_type           used;
   logic                   raw_kind;
   logic                   mfm_kind;

   // The response register can take a new result whenever it is empty or being read.
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   assign raw_kind = (req_chan.elem_kind == KIND_SYNC) || (req_chan.elem_kind == KIND_RAW);
   assign mfm_kind = (req_chan.elem_kind == KIND_DATA) || (req_chan.elem_kind == KIND_GAP);

   // Number of cells the current request wants to append. Only one of them is live
   // per operation, so a single adder and compare serves the overflow check.
   always_comb begin
      case (req_chan.op)
         OP_ELEMENT:   need = mfm_kind ? cell_cnt_type'(16) : cell_cnt_type'(8);
         OP_FUZZY:     need = cell_cnt_type'(req_chan.fuzzy_cells);
         OP_BLOCK_END: need = cell_cnt_type'(req_chan.gap_cells);
         default:      need = '0;
      endcase
   end

   assign need_sum = {1'b0, cell_pos_ff} + {1'b0, need};
   assign overflow = need_sum > {1'b0, exp_track_ff};
   assign used     = cell_pos_ff - block_start_ff;

   always_comb begin
      cell_pos_in    = cell_pos_ff;
      block_start_in = block_start_ff;
      exp_track_in   = exp_track_ff;
      exp_block_in   = exp_block_ff;
      last_bit_in    = last_bit_ff;
      err_in         = err_ff;
      cells_in       = '0;
      count_in       = COUNT_NONE;
      run_in         = '0;
      is_gap_in      = 1'b0;
      first_in       = 1'b0;
      done_in        = 1'b0;

      if (req_chan.op == OP_TRACK_START) begin
         // A new track wipes everything, including a sticky error.
         cell_pos_in    = '0;
         block_start_in = '0;
         exp_block_in   = '0;
         last_bit_in    = 1'b0;
         err_in         = ST_OK;
         exp_track_in   = cell_cnt_type'(req_chan.track_cells);
      end else if (err_ff == ST_OK) begin
         case (req_chan.op)
            OP_BLOCK_START: begin
               block_start_in = cell_pos_ff;
               exp_block_in   = cell_cnt_type'(req_chan.block_cells);
            end
            OP_ELEMENT: begin
               if (!raw_kind && !mfm_kind) begin
                  err_in = ST_BAD_TYPE;
               end else if (overflow) begin
                  err_in = ST_OVERFLOW;
               end else if (raw_kind) begin
                  // Sync and raw bytes go out unencoded; their last cell is the context.
                  cells_in    = {req_chan.value_byte, 8'h00};
                  count_in    = COUNT_RAW;
                  last_bit_in = req_chan.value_byte[0];
                  cell_pos_in = need_sum[CellCountBits-1:0];
               end else begin
                  cells_in    = mfm_encode(req_chan.value_byte, last_bit_ff);
                  count_in    = COUNT_MFM;
                  last_bit_in = req_chan.value_byte[0];
                  cell_pos_in = need_sum[CellCountBits-1:0];
               end
            end
            OP_FUZZY: begin
               if (overflow) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  run_in      = req_chan.fuzzy_cells;
                  cell_pos_in = need_sum[CellCountBits-1:0];
               end
            end
            OP_BLOCK_END: begin
               // Block length is checked before the gap is considered at all.
               if (used != exp_block_ff) begin
                  err_in = ST_BLOCK;
               end else if (req_chan.gap_cells != '0) begin
                  if (overflow) begin
                     err_in = ST_OVERFLOW;
                  end else if (req_chan.gap_cells[0]) begin
                     err_in = ST_ODD_GAP;
                  end else begin
                     run_in      = req_chan.gap_cells;
                     is_gap_in   = 1'b1;
                     first_in    = ~last_bit_ff;
                     last_bit_in = 1'b0;
                     cell_pos_in = need_sum[CellCountBits-1:0];
                  end
               end
            end
            OP_TRACK_END: begin
               if (cell_pos_ff != exp_track_ff) begin
                  err_in = ST_TRACK;
               end else begin
                  done_in = 1'b1;
               end
            end
            default: begin
               // Unused operation codes leave the state untouched.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_pos_ff    <= '0;
         block_start_ff <= '0;
         exp_track_ff   <= '0;
         exp_block_ff   <= '0;
         last_bit_ff    <= 1'b0;
         err_ff         <= ST_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            cell_pos_ff    <= cell_pos_in;
            block_start_ff <= block_start_in;
            exp_track_ff   <= exp_track_in;
            exp_block_ff   <= exp_block_in;
            last_bit_ff    <= last_bit_in;
            err_ff         <= err_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // Response payload; loaded only when a transaction is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         cells_ff  <= cells_in;
         count_ff  <= count_in;
         run_ff    <= run_in;
         is_gap_ff <= is_gap_in;
         first_ff  <= first_in;
         done_ff   <= done_in;
      end
   end

   // The status field reports the error code as it stands after the transaction.
   logic [StatusBits-1:0] status_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= err_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cells          = cells_ff;
   assign rsp_chan.cell_count     = count_ff;
   assign rsp_chan.run_cells      = run_ff;
   assign rsp_chan.run_is_gap     = is_gap_ff;
   assign rsp_chan.gap_first_cell = first_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.track_done     = done_ff;

   // A shown response carries no cells, one raw byte or one encoded byte.
   a_cell_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (count_ff == COUNT_NONE || count_ff == COUNT_RAW ||
                        count_ff == COUNT_MFM))
      else $error("cell_count outside the legal set");

   // A finished track can only be reported with a clean status.
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (status_ff == ST_OK && count_ff == COUNT_NONE))
      else $error("track_done with error status or cells");

   // A gap run is even, nonzero and never shares a response with cells.
   a_gap_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && is_gap_ff) |-> (run_ff != '0 && !run_ff[0] && count_ff == COUNT_NONE))
      else $error("malformed gap run");

   // Once set, an error freezes the track state until a track start arrives.
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && err_ff != ST_OK && req_chan.op != OP_TRACK_START) |=>
         (err_ff == $past(err_ff) && cell_pos_ff == $past(cell_pos_ff) && !done_ff))
      else $error("sticky error state changed");

endmodule

@@ dv/track_element_mfm_cell_builder_tb.sv @@
// Self-checking testbench for track_element_mfm_cell_builder: a directed table, then random
// tracks of blocks and elements, checked against typed rows or a built-in cell builder model.
// Depends on mfmcb_pkg and the mfmcb_req_if / mfmcb_rsp_if channel interfaces.
module track_element_mfm_cell_builder_tb
   import mfmcb_pkg::*;
();

   // Op codes and element kinds that the block does not define. Ops six and seven are
   // ignored outright; kinds outside sync, data, gap and raw are rejected as bad type.
   localparam logic [OpBits-1:0]   OP_SPARE_6   = 3'd6;
   localparam logic [OpBits-1:0]   OP_SPARE_7   = 3'd7;
   localparam logic [KindBits-1:0] KIND_UNUSED0 = 3'd0;

   localparam int RANDOM_ITEMS = 600;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_LIMIT  = 400;

   // One request transaction and one response transaction, at the block's widths.
   typedef struct packed {
      logic [OpBits-1:0]   op;
      logic [19:0]         track_cells;
      logic [19:0]         block_cells;
      logic [19:0]         gap_cells;
      logic [KindBits-1:0] elem_kind;
      logic [7:0]          value_byte;
      logic [19:0]         fuzzy_cells;
   } req_item_type;

   typedef struct packed {
      logic [15:0]           cells;
      logic [CountBits-1:0]  cell_count;
      logic [19:0]           run_cells;
      logic                  run_is_gap;
      logic                  gap_first_cell;
      logic [StatusBits-1:0] status;
      logic                  track_done;
   } rsp_item_type;

   // A row of the directed table. When fixed_rsp is set the response is typed in the row;
   // otherwise it comes from the model below.
   typedef struct {
      req_item_type req;
      bit           fixed_rsp;
      rsp_item_type rsp;
   } table_row_type;

   logic clock;
   logic reset;

   mfmcb_req_if req_bus ();
   mfmcb_rsp_if rsp_bus ();

   track_element_mfm_cell_builder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Track model: its own copy of the position counters, the expected
   // lengths, the MFM context bit and the sticky error.
   // ------------------------------------------------------------------
   cell_cnt_type           cell_pos;
   cell_cnt_type           blk_origin;
   cell_cnt_type           trk_len;
   cell_cnt_type           blk_len;
   logic                   prev_data_bit;
   logic [StatusBits-1:0]  sticky_err;

   rsp_item_type  expected_cells[$];
   req_item_type  track_items[$];
   table_row_type directed_rows[$];

   int mismatches  = 0;
   int cycle_count = 0;
   int rsp_seen    = 0;

   // True when n more cells would run past the end of the track. The sum is one bit
   // wider than the counters so that it cannot wrap.
   function automatic bit passes_end(cell_cnt_type n);
      return ({1'b0, cell_pos} + {1'b0, n}) > {1'b0, trk_len};
   endfunction

   // Applies one request to the model state and returns the response it must produce.
   function automatic rsp_item_type compute_cells(req_item_type r);
      rsp_item_type o;
      cell_cnt_type used;
      logic         d;
      int           i;
      o = '0;
      if (r.op == OP_TRACK_START) begin
         // A track start is the only way out of an error.
         cell_pos      = '0;
         blk_origin    = '0;
         blk_len       = '0;
         prev_data_bit = 1'b0;
         sticky_err    = ST_OK;
         trk_len       = r.track_cells;
      end else if (sticky_err == ST_OK) begin
         case (r.op)
            OP_BLOCK_START: begin
               blk_origin = cell_pos;
               blk_len    = r.block_cells;
            end
            OP_ELEMENT: begin
               if (r.elem_kind == KIND_SYNC || r.elem_kind == KIND_RAW) begin
                  // Sync and raw bytes go out as they are; the last cell is the new context.
                  if (passes_end(cell_cnt_type'(8))) begin
                     sticky_err = ST_OVERFLOW;
                  end else begin
                     o.cells       = {r.value_byte, 8'h00};
                     o.cell_count  = COUNT_RAW;
                     prev_data_bit = r.value_byte[0];
                     cell_pos      = cell_pos + cell_cnt_type'(8);
                  end
               end else if (r.elem_kind == KIND_DATA || r.elem_kind == KIND_GAP) begin
                  if (passes_end(cell_cnt_type'(16))) begin
                     sticky_err = ST_OVERFLOW;
                  end else begin
                     // Clock cell first, then data cell, MSB of the byte first.
                     for (i = 7; i >= 0; i--) begin
                        d                = r.value_byte[i];
                        o.cells[2*i+1]   = (prev_data_bit == 1'b0) && (d == 1'b0);
                        o.cells[2*i]     = d;
                        prev_data_bit    = d;
                     end
                     o.cell_count = COUNT_MFM;
                     cell_pos     = cell_pos + cell_cnt_type'(16);
                  end
               end else begin
                  sticky_err = ST_BAD_TYPE;
               end
            end
            OP_FUZZY: begin
               if (passes_end(r.fuzzy_cells)) begin
                  sticky_err = ST_OVERFLOW;
               end else begin
                  o.run_cells = r.fuzzy_cells;
                  cell_pos    = cell_pos + r.fuzzy_cells;
               end
            end
            OP_BLOCK_END: begin
               // Length check first, then overflow, then odd gap; a zero gap makes no run.
               used = cell_pos - blk_origin;
               if (used != blk_len) begin
                  sticky_err = ST_BLOCK;
               end else if (r.gap_cells != '0) begin
                  if (passes_end(r.gap_cells)) begin
                     sticky_err = ST_OVERFLOW;
                  end else if (r.gap_cells[0]) begin
                     sticky_err = ST_ODD_GAP;
                  end else begin
                     o.run_cells      = r.gap_cells;
                     o.run_is_gap     = 1'b1;
                     o.gap_first_cell = ~prev_data_bit;
                     prev_data_bit    = 1'b0;
                     cell_pos         = cell_pos + r.gap_cells;
                  end
               end
            end
            OP_TRACK_END: begin
               if (cell_pos != trk_len) begin
                  sticky_err = ST_TRACK;
               end else begin
                  o.track_done = 1'b1;
               end
            end
            default: ;
         endcase
      end
      o.status = sticky_err;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Builds a request with every field random, then sets the fields that the op uses.
   // The unused fields stay random to show that the block ignores them.
   function automatic req_item_type make_req(logic [OpBits-1:0] op, cell_cnt_type amount,
                                             logic [KindBits-1:0] kind, logic [7:0] value);
      req_item_type r;
      r.op          = op;
      r.track_cells = 20'($urandom);
      r.block_cells = 20'($urandom);
      r.gap_cells   = 20'($urandom);
      r.elem_kind   = 3'($urandom);
      r.value_byte  = 8'($urandom);
      r.fuzzy_cells = 20'($urandom);
      case (op)
         OP_TRACK_START: r.track_cells = amount;
         OP_BLOCK_START: r.block_cells = amount;
         OP_FUZZY:       r.fuzzy_cells = amount;
         OP_BLOCK_END:   r.gap_cells   = amount;
         OP_ELEMENT: begin
            r.elem_kind  = kind;
            r.value_byte = value;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic rsp_item_type status_only(logic [StatusBits-1:0] st, logic done);
      rsp_item_type o;
      o            = '0;
      o.status     = st;
      o.track_done = done;
      return o;
   endfunction

   function automatic void add_row(req_item_type r, bit fixed_rsp, rsp_item_type rsp);
      table_row_type row;
      row.req       = r;
      row.fixed_rsp = fixed_rsp;
      row.rsp       = rsp;
      directed_rows.push_back(row);
   endfunction

   // Idle length between transactions: mostly none or short, now and then long, and
   // from time to time a calm stretch with no idling at all.
   task automatic pick_gap(inout int calm, output int gap);
      int r;
      if (calm > 0) begin
         calm--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            calm = $urandom_range(10, 60);
            gap  = 0;
         end else if (r < 55) begin
            gap = 0;
         end else if (r < 88) begin
            gap = $urandom_range(1, 3);
         end else if (r < 98) begin
            gap = $urandom_range(4, 12);
         end else begin
            gap = $urandom_range(20, 50);
         end
      end
   endtask

   // Queues one random track: a track start, up to three blocks of elements and fuzzy
   // runs, each closed by a block end with a gap, and usually a track end. Most tracks are well
   // formed so that they reach the block end and track end checks; some carry a wrong
   // length, an odd gap, a missing block start or stray noise transactions.
   task automatic queue_track();
      req_item_type        body[$];
      req_item_type        blk[$];
      int unsigned         total;
      int unsigned         data_len;
      int unsigned         gap_len;
      int unsigned         n;
      int unsigned         pick;
      cell_cnt_type        len;
      cell_cnt_type        blk_field;
      logic [KindBits-1:0] kind;
      total = 0;
      repeat ($urandom_range(0, 3)) begin
         blk.delete();
         data_len = 0;
         repeat ($urandom_range(0, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               case ($urandom_range(0, 3))
                  0:       kind = KIND_SYNC;
                  1:       kind = KIND_DATA;
                  2:       kind = KIND_GAP;
                  default: kind = KIND_RAW;
               endcase
               n = (kind == KIND_SYNC || kind == KIND_RAW) ? 8 : 16;
               blk.push_back(make_req(OP_ELEMENT, '0, kind, 8'($urandom)));
            end else if (pick < 88) begin
               n = $urandom_range(0, 24);
               blk.push_back(make_req(OP_FUZZY, cell_cnt_type'(n), KIND_UNUSED0, '0));
            end else if (pick < 94) begin
               n = $urandom_range(0, 'h1FFFF);
               blk.push_back(make_req(OP_FUZZY, cell_cnt_type'(n), KIND_UNUSED0, '0));
            end else begin
               // Noise: any op, any kind, any field value.
               n = 0;
               blk.push_back(make_req(3'($urandom), 20'($urandom), 3'($urandom),
                                      8'($urandom)));
            end
            data_len += n;
         end
         gap_len = 2 * $urandom_range(0, 24);
         if ($urandom_range(0, 11) == 0) gap_len += 1;
         blk_field = cell_cnt_type'(data_len);
         if ($urandom_range(0, 11) == 0) blk_field = blk_field + 20'($urandom_range(1, 16));
         if ($urandom_range(0, 14) != 0) begin
            body.push_back(make_req(OP_BLOCK_START, blk_field, KIND_UNUSED0, '0));
         end
         foreach (blk[i]) body.push_back(blk[i]);
         body.push_back(make_req(OP_BLOCK_END, cell_cnt_type'(gap_len), KIND_UNUSED0, '0));
         total += data_len + gap_len;
      end
      // Mostly the exact length; sometimes short (overflow), long (track mismatch) or wild.
      len  = cell_cnt_type'(total);
      pick = $urandom_range(0, 29);
      if (pick < 3) begin
         len = len - 20'($urandom_range(1, 16));
      end else if (pick < 6) begin
         len = len + 20'($urandom_range(1, 16));
      end else if (pick == 6) begin
         len = 20'($urandom);
      end
      track_items.push_back(make_req(OP_TRACK_START, len, KIND_UNUSED0, '0));
      foreach (body[i]) track_items.push_back(body[i]);
      if ($urandom_range(0, 19) != 0) begin
         track_items.push_back(make_req(OP_TRACK_END, '0, KIND_UNUSED0, '0));
      end
   endtask

   // ------------------------------------------------------------------
   // Request side. The transaction completes at the edge where valid and
   // ready are both high; valid stays up between back-to-back transactions.
   // ------------------------------------------------------------------
   int send_calm = 0;

   task automatic send_req(req_item_type r);
      int gap;
      pick_gap(send_calm, gap);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= r.op;
      req_bus.track_cells <= r.track_cells;
      req_bus.block_cells <= r.block_cells;
      req_bus.gap_cells   <= r.gap_cells;
      req_bus.elem_kind   <= r.elem_kind;
      req_bus.value_byte  <= r.value_byte;
      req_bus.fuzzy_cells <= r.fuzzy_cells;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Every failure goes through here: one line each, and every one is counted.
   task automatic note_mismatch(string msg);
      mismatches++;
      $display("MISMATCH response %0d: %s", rsp_seen, msg);
   endtask

   task automatic check_field(string name, int unsigned got, int unsigned want);
      if (got != want) begin
         note_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence: reset, the directed table, random tracks, then drain.
   // ------------------------------------------------------------------
   initial begin : stimulus
      rsp_item_type model_rsp;
      int           random_sent;
      int           waited;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= OP_TRACK_START;
      req_bus.track_cells <= '0;
      req_bus.block_cells <= '0;
      req_bus.gap_cells   <= '0;
      req_bus.elem_kind   <= KIND_UNUSED0;
      req_bus.value_byte  <= '0;
      req_bus.fuzzy_cells <= '0;

      // Straight out of reset the track length is zero, so a track end succeeds at once.
      add_row(make_req(OP_TRACK_END,   '0, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b1));
      // A full-length track with one block of every element kind, an empty fuzzy run and
      // a two-cell gap. The raw zero byte leaves a zero context, so the gap starts with a
      // clock cell.
      add_row(make_req(OP_TRACK_START, 20'hFFFFF, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_BLOCK_START, 20'd48, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_ELEMENT,     '0, KIND_SYNC, 8'hA1), 1'b0, '0);
      add_row(make_req(OP_ELEMENT,     '0, KIND_DATA, 8'h00), 1'b0, '0);
      add_row(make_req(OP_ELEMENT,     '0, KIND_GAP,  8'hFF), 1'b0, '0);
      add_row(make_req(OP_ELEMENT,     '0, KIND_RAW,  8'h00), 1'b0, '0);
      add_row(make_req(OP_FUZZY,       '0, KIND_UNUSED0, '0), 1'b0, '0);
      add_row(make_req(OP_BLOCK_END,   20'd2, KIND_UNUSED0, '0), 1'b0, '0);
      // The track is far from full, so its end is a mismatch, and the error sticks.
      add_row(make_req(OP_TRACK_END,   '0, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_TRACK, 1'b0));
      add_row(make_req(OP_SPARE_7,     '0, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_TRACK, 1'b0));
      // A zero-length track cannot take even one sync byte.
      add_row(make_req(OP_TRACK_START, '0, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_ELEMENT,     '0, KIND_SYNC, 8'hFF), 1'b1,
              status_only(ST_OVERFLOW, 1'b0));
      // Block end with no block start and no gap passes; an odd gap does not.
      add_row(make_req(OP_TRACK_START, 20'd64, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_BLOCK_END,   '0, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_BLOCK_END,   20'd3, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_ODD_GAP, 1'b0));
      // Block length mismatch.
      add_row(make_req(OP_TRACK_START, 20'd64, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_BLOCK_START, 20'd5, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_BLOCK_END,   20'd2, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_BLOCK, 1'b0));
      // A gap that runs past the end of the track.
      add_row(make_req(OP_TRACK_START, 20'd64, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_BLOCK_END,   20'd66, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OVERFLOW, 1'b0));
      // An element kind outside the four defined ones.
      add_row(make_req(OP_TRACK_START, 20'hFFFFF, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_ELEMENT,     '0, KIND_UNUSED0, 8'h5A), 1'b1,
              status_only(ST_BAD_TYPE, 1'b0));
      // One fuzzy run of the largest size fills a full-length track exactly.
      add_row(make_req(OP_TRACK_START, 20'hFFFFF, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b0));
      add_row(make_req(OP_FUZZY,       20'hFFFFF, KIND_UNUSED0, '0), 1'b0, '0);
      add_row(make_req(OP_TRACK_END,   '0, KIND_UNUSED0, '0), 1'b1,
              status_only(ST_OK, 1'b1));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The model leaves reset in the same state as the block.
      cell_pos      = '0;
      blk_origin    = '0;
      trk_len       = '0;
      blk_len       = '0;
      prev_data_bit = 1'b0;
      sticky_err    = ST_OK;

      // The expectation is queued at the edge where the request transaction completes,
      // before its response transaction can complete.
      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].req);
         model_rsp = compute_cells(directed_rows[i].req);
         expected_cells.push_back(directed_rows[i].fixed_rsp ? directed_rows[i].rsp : model_rsp);
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         queue_track();
         while (track_items.size() != 0) begin
            send_req(track_items[0]);
            expected_cells.push_back(compute_cells(track_items[0]));
            // Spare op codes are ignored and do not count toward the random total.
            if (track_items[0].op <= OP_TRACK_END) random_sent++;
            void'(track_items.pop_front());
         end
      end
      req_bus.valid <= 1'b0;

      // Drain: every expected response must come out within a bounded wait.
      waited = 0;
      while (expected_cells.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (expected_cells.size() != 0) begin
         note_mismatch($sformatf("%0d responses never arrived", expected_cells.size()));
      end

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: ready is held high until a transaction completes, then
   // dropped for a random stall, at times none, before the next one.
   // ------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int calm;
      int gap;
      calm = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pick_gap(calm, gap);
         if (gap != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Compares each completed response transaction, field by field, with the oldest
   // expectation. Values are read right after the edge, so they are the ones the edge saw.
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_seen++;
         if (expected_cells.size() == 0) begin
            note_mismatch("response with nothing expected");
         end else begin
            want = expected_cells.pop_front();
            check_field("cells",          32'(rsp_bus.cells),          32'(want.cells));
            check_field("cell_count",     32'(rsp_bus.cell_count),     32'(want.cell_count));
            check_field("run_cells",      32'(rsp_bus.run_cells),      32'(want.run_cells));
            check_field("run_is_gap",     32'(rsp_bus.run_is_gap),     32'(want.run_is_gap));
            check_field("gap_first_cell", 32'(rsp_bus.gap_first_cell),
                        32'(want.gap_first_cell));
            check_field("status",         32'(rsp_bus.status),         32'(want.status));
            check_field("track_done",     32'(rsp_bus.track_done),     32'(want.track_done));
         end
      end
   end

   // Hard stop in case either handshake hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
